### rtl/multi_stack_shared_store_defines.svh
// Assertion macros for the checker of the block.
`ifndef MULTI_STACK_SHARED_STORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_DEFINES_SVH

// Same-cycle implication.
`define MSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mss_pkg.sv
package mss_pkg;

   localparam int NUM_STACKS_DEF = 8;
   localparam int CAPACITY_DEF   = 64;

   localparam int STACK_W     = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

### rtl/multi_stack_shared_store.sv
// NUM_STACKS LIFO stacks share one store of CAPACITY slots; unused slots form a linked free
// list, and slots never yet handed out are tracked by a fill count instead of a clearing pass,
// so the block takes items right after reset. Each request (tuser 0 push, 1 pop) gives one
// response with a status (done, push refused because the store is full or the stack number is
// out of range, pop refused because the stack is empty or out of range) and the popped value.
// A push reads the stack top and the free-list link in parallel from the top memory and the
// slot memory, then writes them back. A pop goes on to S_POP, since its slot read
// in the slot memory can only start once the stack top has come out of the top memory. A
// refused pop ends in S_LOOK. A finished response waits in the output register while the next
// request is taken; an item stalls only when a new response is due and the old one is unread.
module multi_stack_shared_store
   import mss_pkg::*;
#(
   parameter int NUM_STACKS = NUM_STACKS_DEF,
   parameter int CAPACITY   = CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [2:0] stack_number, [34:3] push_value
   input  logic                   req_tuser,  // [0] operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [1:0] status, [33:2] pop_value
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SW = PW + VALUE_W;
   localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_POP
   } state_type;

   logic [SW-1:0]         slot_mem [CAPACITY];
   logic [PW-1:0]         tops_mem [NUM_STACKS];

   state_type             state_ff, state_in;
   logic [NUM_STACKS-1:0] tops_vld_ff, tops_vld_in;
   logic [PW-1:0]         free_head_ff, free_head_in;
   logic [PW-1:0]         fresh_ff, fresh_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   op_type                op_ff;
   logic [STACK_W-1:0]    sn_ff;
   logic [VALUE_W-1:0]    val_ff;
   logic [SW-1:0]         slot_rd_ff;
   logic [PW-1:0]         top_rd_ff;

   logic [STACK_W-1:0]    req_sn;
   logic [VALUE_W-1:0]    req_val;
   logic [STACK_W+TW-1:0] req_sn_ext, sn_ext;
   logic [TW-1:0]         req_idx, idx;
   logic                  accept, out_free, sn_ok, has_free, has_top, fresh_slot;
   logic [PW-1:0]         top_ptr, next_free, slot_link;
   logic                  finish, do_push, do_pop;
   logic                  slot_rd_en, slot_wr_en, tops_wr_en;
   logic [AW-1:0]         slot_rd_addr, slot_wr_addr;
   logic [SW-1:0]         slot_wr_data;
   logic [PW-1:0]         tops_wr_data;

   assign req_sn     = req_tdata[STACK_W-1:0];
   assign req_val    = req_tdata[STACK_W+VALUE_W-1:STACK_W];
   assign req_sn_ext = {TW'(0), req_sn};
   assign req_idx    = req_sn_ext[TW-1:0];
   assign sn_ext     = {TW'(0), sn_ff};
   assign idx        = sn_ext[TW-1:0];

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign sn_ok      = int'(sn_ff) < NUM_STACKS;
   assign top_ptr    = tops_vld_ff[idx] ? top_rd_ff : NULL_PTR;
   assign has_top    = top_ptr < NULL_PTR;
   assign has_free   = free_head_ff < NULL_PTR;
   assign fresh_slot = free_head_ff == fresh_ff;
   assign slot_link  = slot_rd_ff[SW-1:VALUE_W];
   assign next_free  = fresh_slot ? PW'(fresh_ff + 1'b1) : slot_link;

   always_comb begin
      state_in   = state_ff;
      finish     = 1'b0;
      slot_rd_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in   = S_LOOK;
               slot_rd_en = 1'b1;
            end
         end
         S_LOOK: begin
            if (op_ff == OP_POP && sn_ok && has_top) begin
               state_in   = S_POP;
               slot_rd_en = 1'b1;
            end else if (out_free) begin
               state_in = S_IDLE;
               finish   = 1'b1;
            end
         end
         S_POP: begin
            if (out_free) begin
               state_in = S_IDLE;
               finish   = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign slot_rd_addr = (state_ff == S_IDLE) ? free_head_ff[AW-1:0] : top_ptr[AW-1:0];

   assign do_push = finish && (state_ff == S_LOOK) && (op_ff == OP_PUSH) && sn_ok && has_free;
   assign do_pop  = finish && (state_ff == S_POP);

   assign slot_wr_en   = do_push || do_pop;
   assign slot_wr_addr = do_push ? free_head_ff[AW-1:0] : top_ptr[AW-1:0];
   assign slot_wr_data = do_push ? {top_ptr, val_ff} : {free_head_ff, slot_rd_ff[VALUE_W-1:0]};
   assign tops_wr_en   = do_push || do_pop;
   assign tops_wr_data = do_push ? free_head_ff : slot_link;

   always_comb begin
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      tops_vld_in   = tops_vld_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (do_push) begin
         free_head_in = next_free;
         if (fresh_slot) begin
            fresh_in = PW'(fresh_ff + 1'b1);
         end
      end else if (do_pop) begin
         free_head_in = top_ptr;
      end
      if (tops_wr_en) begin
         tops_vld_in[idx] = 1'b1;
      end
      if (finish) begin
         rsp_tvalid_in = 1'b1;
         rsp_value_in  = do_pop ? slot_rd_ff[VALUE_W-1:0] : '0;
         if (do_push || do_pop) begin
            rsp_status_in = ST_OK;
         end else if (op_ff == OP_PUSH) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= '0;
         fresh_ff      <= '0;
         tops_vld_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_value_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         fresh_ff      <= fresh_in;
         tops_vld_ff   <= tops_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   // hold the request while it is worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_tuser);
         sn_ff  <= req_sn;
         val_ff <= req_val;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tops_wr_en) begin
         tops_mem[idx] <= tops_wr_data;
      end
      if (accept) begin
         top_rd_ff <= tops_mem[req_idx];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - STATUS_W)'(0), rsp_value_ff, rsp_status_ff};

endmodule

### rtl/mss_checker.sv
`include "multi_stack_shared_store_defines.svh"

module mss_checker
   import mss_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                req_acc;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_value;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_value  = rsp_tdata[STATUS_W+VALUE_W-1:STATUS_W];

   `MSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `MSS_ASSERT_IMPLY(a_refused_zero, clock, reset, rsp_tvalid && rsp_status != ST_OK,
      rsp_value == '0, "refused item carries a value")
   `MSS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_acc, !req_tready,
      "request taken while busy")
   `MSS_ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_tvalid),
      $past(req_acc, 2) || $past(req_acc, 3), "response without a matching request")

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (.*);
